>>> src/mmt_pkg.sv
package mmt_pkg;

    // fixed widths of the channel fields
    localparam int MODE_W  = 2;
    localparam int FIELD_W = 32;
    localparam int TOTAL_W = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT     = 2'd0,
        MODE_REMOVE     = 2'd1,
        MODE_SEARCH     = 2'd2,
        MODE_PUT_ABSENT = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_PRESENT   = 2'd3
    } status_t;

    typedef struct packed {
        mode_t               mode;
        logic signed [31:0]  key;
        logic signed [31:0]  item_value;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic                found;
        logic signed [31:0]  found_value;
        logic                last;
        logic [TOTAL_W-1:0]  entry_total;
        logic                is_empty;
    } rsp_t;

    // read pointer moves
    typedef enum logic [1:0] {
        ADDR_TOP  = 2'd0,
        ADDR_HOLD = 2'd1,
        ADDR_DOWN = 2'd2,
        ADDR_UP   = 2'd3
    } addr_sel_t;

    // what goes into the output register
    typedef enum logic [2:0] {
        EMIT_NONE       = 3'd0,
        EMIT_MATCH      = 3'd1,
        EMIT_MATCH_LAST = 3'd2,
        EMIT_MISS       = 3'd3,
        EMIT_STATUS     = 3'd4
    } emit_t;

    typedef struct packed {
        logic       in_ready;
        addr_sel_t  addr_sel;
        logic       put_wr;
        logic       shift_wr;
        logic       count_dec;
        logic       status_we;
        status_t    status_val;
        logic       pend_load;
        emit_t      emit;
    } dp_cmd_t;

    typedef struct packed {
        logic   in_valid;
        mode_t  in_mode;
        mode_t  op_mode;
        logic   count_zero;
        logic   key_eq;
        logic   pair_eq;
        logic   at_bottom;
        logic   at_top;
        logic   pend_valid;
        logic   out_free;
    } dp_stat_t;

endpackage

>>> src/mmt_stream_if.sv
interface mmt_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> src/mmt_datapath.sv
module mmt_datapath #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    mmt_stream_if.sink        req,
    mmt_stream_if.source      rsp,
    input  mmt_pkg::dp_cmd_t  cmd,
    output mmt_pkg::dp_stat_t stat
);
    import mmt_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // pair storage, one write and one registered read per cycle
    logic [KEY_BITS-1:0]   key_mem [CAPACITY];
    logic [VALUE_BITS-1:0] val_mem [CAPACITY];

    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;
    logic [IDX_W-1:0]      ptr_reg, ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    mode_t                 op_mode_reg;
    logic [KEY_BITS-1:0]   op_key_reg;
    logic [VALUE_BITS-1:0] op_val_reg;
    status_t               status_reg, status_next;

    logic                  pend_valid_reg, pend_valid_next;
    logic [VALUE_BITS-1:0] pend_val_reg;

    logic                  out_valid_reg, out_valid_next;
    rsp_t                  out_reg, out_next;

    logic                  accept;
    logic                  full;
    logic                  count_zero;
    logic [IDX_W-1:0]      count_top;
    logic                  put_en;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0] wr_val;

    assign accept     = req.valid && cmd.in_ready;
    assign req.ready  = cmd.in_ready;
    assign full       = count_reg >= CNT_W'(CAPACITY);
    assign count_zero = count_reg == '0;
    assign count_top  = count_zero ? '0 : IDX_W'(count_reg - CNT_W'(1));
    assign put_en     = cmd.put_wr && !full;

    // status toward the controller
    always_comb
    begin
        stat.in_valid   = req.valid;
        stat.in_mode    = req.payload.mode;
        stat.op_mode    = op_mode_reg;
        stat.count_zero = count_zero;
        stat.key_eq     = rd_key_reg == op_key_reg;
        stat.pair_eq    = (rd_key_reg == op_key_reg) && (rd_val_reg == op_val_reg);
        stat.at_bottom  = ptr_reg == '0;
        stat.at_top     = ptr_reg == count_top;
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = !out_valid_reg || rsp.ready;
    end

    // read pointer
    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_TOP:  ptr_next = count_top;
            ADDR_HOLD: ptr_next = ptr_reg;
            ADDR_DOWN: ptr_next = ptr_reg - IDX_W'(1);
            ADDR_UP:   ptr_next = ptr_reg + IDX_W'(1);
            default:   ptr_next = ptr_reg;
        endcase
    end

    // write port: append at the end, or move an entry one place down
    always_comb
    begin
        wr_en   = put_en || cmd.shift_wr;
        wr_addr = cmd.shift_wr ? (ptr_reg - IDX_W'(1)) : IDX_W'(count_reg);
        wr_key  = cmd.shift_wr ? rd_key_reg : op_key_reg;
        wr_val  = cmd.shift_wr ? rd_val_reg : op_val_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
        rd_key_reg <= key_mem[ptr_next];
        rd_val_reg <= val_mem[ptr_next];
    end

    // entry count and status
    always_comb
    begin
        count_next = count_reg;
        if (put_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        status_next = status_reg;
        if (cmd.put_wr)
        begin
            status_next = full ? ST_FULL : ST_OK;
        end
        else if (cmd.status_we)
        begin
            status_next = cmd.status_val;
        end
    end

    // pending search match, held until we know whether it is the oldest
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (accept || cmd.emit == EMIT_MATCH_LAST || cmd.emit == EMIT_MISS)
        begin
            pend_valid_next = 1'b0;
        end
        else if (cmd.pend_load)
        begin
            pend_valid_next = 1'b1;
        end
    end

    // output register
    always_comb
    begin
        out_next             = out_reg;
        out_next.entry_total = TOTAL_W'(count_reg);
        out_next.is_empty    = count_zero;
        out_next.status      = ST_OK;
        out_next.found       = 1'b1;
        out_next.found_value = FIELD_W'($signed(pend_val_reg));
        out_next.last        = 1'b0;
        out_valid_next       = out_valid_reg && !rsp.ready;
        case (cmd.emit)
            EMIT_MATCH:
            begin
                out_valid_next = 1'b1;
            end
            EMIT_MATCH_LAST:
            begin
                out_next.last  = 1'b1;
                out_valid_next = 1'b1;
            end
            EMIT_MISS:
            begin
                out_next.status      = ST_NOT_FOUND;
                out_next.found       = 1'b0;
                out_next.found_value = '0;
                out_next.last        = 1'b1;
                out_valid_next       = 1'b1;
            end
            EMIT_STATUS:
            begin
                out_next.status      = status_reg;
                out_next.found       = 1'b0;
                out_next.found_value = '0;
                out_next.last        = 1'b1;
                out_valid_next       = 1'b1;
            end
            default:
            begin
                out_next = out_reg;
            end
        endcase
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= '0;
            count_reg      <= '0;
            status_reg     <= ST_OK;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ptr_reg        <= ptr_next;
            count_reg      <= count_next;
            status_reg     <= status_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_mode_reg <= req.payload.mode;
            op_key_reg  <= KEY_BITS'($signed(req.payload.key));
            op_val_reg  <= VALUE_BITS'($signed(req.payload.item_value));
        end
        if (cmd.pend_load)
        begin
            pend_val_reg <= rd_val_reg;
        end
        if (cmd.emit != EMIT_NONE)
        begin
            out_reg <= out_next;
        end
    end

endmodule

>>> src/mmt_ctrl.sv
module mmt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  mmt_pkg::dp_stat_t stat,
    output mmt_pkg::dp_cmd_t  cmd
);
    import mmt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_SHIFT  = 6'b000100,
        S_PUT    = 6'b001000,
        S_FLUSH  = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   scan_done;
    logic   key_hit;
    logic   pair_hit;

    // the scan ends at the oldest entry, or at once on an empty table
    assign scan_done = stat.at_bottom || stat.count_zero;
    assign key_hit   = stat.key_eq && !stat.count_zero;
    assign pair_hit  = stat.pair_eq && !stat.count_zero;

    always_comb
    begin
        state_next     = state_reg;
        cmd.in_ready   = 1'b0;
        cmd.addr_sel   = ADDR_HOLD;
        cmd.put_wr     = 1'b0;
        cmd.shift_wr   = 1'b0;
        cmd.count_dec  = 1'b0;
        cmd.status_we  = 1'b0;
        cmd.status_val = ST_OK;
        cmd.pend_load  = 1'b0;
        cmd.emit       = EMIT_NONE;
        case (state_reg)
            // keep the newest entry on the read port while waiting
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.addr_sel = ADDR_TOP;
                if (stat.in_valid)
                begin
                    state_next = (stat.in_mode == MODE_INSERT) ? S_PUT : S_SCAN;
                end
            end

            // walk from newest to oldest, one entry a cycle unless a search match must wait for the output register
            S_SCAN:
            begin
                cmd.addr_sel = ADDR_DOWN;
                case (stat.op_mode)
                    MODE_REMOVE:
                    begin
                        if (pair_hit && stat.at_top)
                        begin
                            cmd.addr_sel  = ADDR_HOLD;
                            cmd.count_dec = 1'b1;
                            cmd.status_we = 1'b1;
                            state_next    = S_RESULT;
                        end
                        else if (pair_hit)
                        begin
                            cmd.addr_sel = ADDR_UP;
                            state_next   = S_SHIFT;
                        end
                        else if (scan_done)
                        begin
                            cmd.addr_sel   = ADDR_HOLD;
                            cmd.status_we  = 1'b1;
                            cmd.status_val = ST_NOT_FOUND;
                            state_next     = S_RESULT;
                        end
                    end
                    MODE_PUT_ABSENT:
                    begin
                        if (pair_hit)
                        begin
                            cmd.addr_sel   = ADDR_HOLD;
                            cmd.status_we  = 1'b1;
                            cmd.status_val = ST_PRESENT;
                            state_next     = S_RESULT;
                        end
                        else if (scan_done)
                        begin
                            cmd.addr_sel = ADDR_HOLD;
                            state_next   = S_PUT;
                        end
                    end
                    MODE_SEARCH:
                    begin
                        if (key_hit && stat.pend_valid && !stat.out_free)
                        begin
                            // previous match cannot leave yet
                            cmd.addr_sel = ADDR_HOLD;
                        end
                        else
                        begin
                            if (key_hit)
                            begin
                                cmd.pend_load = 1'b1;
                                if (stat.pend_valid)
                                begin
                                    cmd.emit = EMIT_MATCH;
                                end
                            end
                            if (scan_done)
                            begin
                                cmd.addr_sel = ADDR_HOLD;
                                state_next   = S_FLUSH;
                            end
                        end
                    end
                    default:
                    begin
                        cmd.addr_sel = ADDR_HOLD;
                        state_next   = S_RESULT;
                    end
                endcase
            end

            // close the gap: copy each younger entry one place down
            S_SHIFT:
            begin
                cmd.shift_wr = 1'b1;
                if (stat.at_top)
                begin
                    cmd.count_dec = 1'b1;
                    cmd.status_we = 1'b1;
                    state_next    = S_RESULT;
                end
                else
                begin
                    cmd.addr_sel = ADDR_UP;
                end
            end

            S_PUT:
            begin
                cmd.put_wr = 1'b1;
                state_next = S_RESULT;
            end

            // oldest match, or the miss beat
            S_FLUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = stat.pend_valid ? EMIT_MATCH_LAST : EMIT_MISS;
                    state_next = S_IDLE;
                end
            end

            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = EMIT_STATUS;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/multimap_table.sv
// Bounded multimap of up to CAPACITY key/value pairs with duplicate keys allowed, kept in
// insertion order in a two-port memory (one write and one registered read per cycle).
// One request beat is taken at a time. Insert appends the pair and then reports its
// status. Search, remove and insert-if-absent walk the stored pairs from newest to oldest
// at one entry per cycle, except while a search waits for the output register, and end
// the scan at once on an empty table. Remove then moves each younger pair one place down
// to close the gap. Search sends one response beat per match, newest first, with last on
// the oldest match, or a single miss beat when none matches, and pauses its walk at a
// further match while the output register is still full. A status beat likewise waits
// for the output register. Every response carries the entry count after the operation
// and an empty flag. The memory needs no clearing after reset.
module multimap_table #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    mmt_stream_if.sink   req,
    mmt_stream_if.source rsp
);
    import mmt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mmt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    mmt_datapath #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule
